/* rtl/hnsc_pkg.sv */
// Package for the H.265 start code splitter: result record, header constants
// and the counted-type check. No dependencies.
`default_nettype none

package hnsc_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int OUT_BITS        = 32;
	localparam int TYPE_BITS       = 6;

	localparam logic [31:0] START_CODE  = 32'h0000_0001;
	localparam logic [7:0]  TYPE_MASK   = 8'h7E;
	localparam logic [2:0]  FILL_FULL   = 3'd4;
	localparam logic [5:0]  TYPE_LAST_LOW = 6'd21;
	localparam logic [5:0]  TYPE_RSV_A  = 6'd19;
	localparam logic [5:0]  TYPE_RSV_B  = 6'd20;
	localparam logic [5:0]  TYPE_VPS    = 6'd32;

	// tdata packing of a result, lowest bit first
	localparam int TDATA_BITS = 104;

	typedef struct packed {
		logic [OUT_BITS-1:0]  vps_total;
		logic [OUT_BITS-1:0]  segment_length;
		logic                 length_valid;
		logic [TYPE_BITS-1:0] unit_type;
		logic [OUT_BITS-1:0]  start_offset;
	} result_t;

	// Unit types that close a counted segment
	function automatic logic type_counted(input logic [TYPE_BITS-1:0] t);
		logic low_ok;
		low_ok = (t <= TYPE_LAST_LOW) && (t != TYPE_RSV_A) && (t != TYPE_RSV_B);
		return low_ok || (t == TYPE_VPS);
	endfunction

endpackage

`default_nettype wire

/* rtl/hevc_nal_start_code_splitter_core.sv */
// Top level of the H.265 Annex B start code splitter.
// Instantiates hnsc_scan and hnsc_out_reg; depends on hnsc_pkg.
//
// Usage:
//   Slave side: one stream byte per transaction on s_tdata.
//   Master side: one transaction per NAL header that follows a four-byte
//   start code 00 00 00 01. Three-byte start codes are not recognized.
//   m_tuser carries length_valid: high when this unit closes a counted
//   segment (types 0..21 other than 19 and 20, or 32), and then
//   segment_length is the byte distance from the previous counted boundary.
//   The first start code of the stream is reported but never counted.
// Path: a header byte passes the input register, then the result register,
//   before it is presented on m_tvalid.
// Throughput: one byte per clock unless a stall drops s_tready; the only
//   loop is the update of the offset, history and boundary registers.
// Reset: arst_n clears history, offsets, the first-code flag, the VPS
//   count and both valid flags; no start code matches until four real
//   bytes have arrived.
// Stall: while m_tready is low a waiting result holds; bytes without a
//   header keep flowing, and s_tready drops only when a header byte
//   finds the result register still full.
`default_nettype none

module hevc_nal_start_code_splitter_core #(
	parameter int OFFSET_BITS = hnsc_pkg::OFFSET_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [7:0]                       s_tdata,  // data_byte[7:0]
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// start_offset[31:0], unit_type[37:32], segment_length[69:38],
	// vps_total[101:70], zero fill [103:102]
	output logic [hnsc_pkg::TDATA_BITS-1:0]  m_tdata,
	output logic                             m_tuser   // length_valid
);
	import hnsc_pkg::*;

	logic    res_valid;
	logic    res_ready;
	result_t res;
	result_t out_res;

	// Detect headers and advance the stream position
	hnsc_scan #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Hold the result until the sink takes it
	hnsc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	// Pack fields, lowest first
	assign m_tdata = {2'b00, out_res.vps_total, out_res.segment_length,
	                  out_res.unit_type, out_res.start_offset};
	assign m_tuser = out_res.length_valid;

	a_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[69:38] == '0))
		else $error("segment length set on an uncounted unit");

	a_drop_only_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without a transaction");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> s_tready)
		else $error("input stalled with a free result register");

endmodule

`default_nettype wire

/* rtl/hnsc_scan.sv */
// Input stage and start code detector: holds the byte history, offsets and
// VPS count, and forms one result record per header. Depends on hnsc_pkg.
`default_nettype none

module hnsc_scan #(
	parameter int OFFSET_BITS = hnsc_pkg::OFFSET_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [7:0]             in_byte,
	output logic                   res_valid,
	input  wire                    res_ready,
	output hnsc_pkg::result_t      res
);
	import hnsc_pkg::*;

	localparam int EXT_BITS = OFFSET_BITS + OUT_BITS;

	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic [31:0]            hist_q;
	logic [2:0]             fill_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] last_boundary_q;
	logic                   first_seen_q;
	logic [OUT_BITS-1:0]    vps_q;

	logic                   hit;
	logic                   advance;
	logic [7:0]             masked;
	logic [TYPE_BITS-1:0]   utype;
	logic                   counted;
	logic [OFFSET_BITS-1:0] start;
	logic [OFFSET_BITS-1:0] seg;
	logic [EXT_BITS-1:0]    start_ext;
	logic [EXT_BITS-1:0]    seg_ext;
	logic [OUT_BITS-1:0]    vps_next;

	always_comb begin
		hit       = (fill_q == FILL_FULL) && (hist_q == START_CODE);
		masked    = data_byte_s1 & TYPE_MASK;
		utype     = masked[TYPE_BITS:1];
		counted   = first_seen_q && type_counted(utype);
		start     = offset_q - OFFSET_BITS'(4);
		seg       = start - last_boundary_q;
		start_ext = {{OUT_BITS{1'b0}}, start};
		seg_ext   = {{OUT_BITS{1'b0}}, seg};
		vps_next  = (first_seen_q && (utype == TYPE_VPS)) ? vps_q + OUT_BITS'(1) : vps_q;

		advance   = valid_s1 && (!hit || res_ready);
		in_ready  = !valid_s1 || advance;
		res_valid = valid_s1 && hit;

		res.start_offset   = start_ext[OUT_BITS-1:0];
		res.unit_type      = utype;
		res.length_valid   = counted;
		res.segment_length = counted ? seg_ext[OUT_BITS-1:0] : '0;
		res.vps_total      = vps_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q          <= '0;
			fill_q          <= '0;
			offset_q        <= '0;
			last_boundary_q <= '0;
			first_seen_q    <= 1'b0;
			vps_q           <= '0;
		end else if (advance) begin
			hist_q   <= {hist_q[23:0], data_byte_s1};
			offset_q <= offset_q + OFFSET_BITS'(1);
			if (fill_q != FILL_FULL) begin
				fill_q <= fill_q + 3'd1;
			end
			if (hit) begin
				first_seen_q <= 1'b1;
				vps_q        <= vps_next;
				if (counted) begin
					last_boundary_q <= start;
				end
			end
		end
	end

	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> offset_q == $past(offset_q) + OFFSET_BITS'(1))
		else $error("offset did not advance by one byte");

	a_vps_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (vps_q == $past(vps_q)) || (vps_q == $past(vps_q) + OUT_BITS'(1)))
		else $error("VPS count jumped");

	a_boundary_move: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && hit && counted) |=> last_boundary_q == $past(start))
		else $error("counted boundary not recorded");

endmodule

`default_nettype wire

/* rtl/hnsc_out_reg.sv */
// Result register toward the master side; frees as soon as the sink takes
// its transaction. Depends on hnsc_pkg.
`default_nettype none

module hnsc_out_reg (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  hnsc_pkg::result_t      in_res,
	output logic                   out_valid,
	input  wire                    out_ready,
	output hnsc_pkg::result_t      out_res
);
	import hnsc_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

`default_nettype wire
